// ===== rtl/core/yolo_cell_box_decode_assert.svh =====
// Assertion macros shared by the box decode RTL.
// Depends on a clk_i / rst_ni pair in the including module.
`ifndef YOLO_CELL_BOX_DECODE_ASSERT_SVH
`define YOLO_CELL_BOX_DECODE_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define YCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another one on the next edge.
`define YCBD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== rtl/core/ycbd_pkg.sv =====
// Package for the box decode block: sequencer states, status struct and
// the fixed-point sigmoid, exp and saturation helpers. No dependencies.
`default_nettype none
package ycbd_pkg;

  localparam int unsigned MaxClasses = 128;
  localparam int unsigned MaxGrid    = 256;
  localparam int unsigned DivW       = 48;
  localparam int unsigned DsrW       = 18;

  localparam logic [1:0] RegNumClasses = 2'd0;
  localparam logic [1:0] RegThreshold  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_LOAD, ST_DIV, ST_FIN, ST_SIZE, ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [16:0] fx_sigmoid(input logic signed [15:0] x);
    logic [16:0] a;
    logic [16:0] y;
    a = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
    if (a < 17'd256)       y = 17'd32768 + {3'b0, a[7:0], 6'b0};
    else if (a < 17'd640)  y = 17'd40960 + {2'b0, a[9:0], 5'b0};
    else if (a < 17'd1152) y = 17'd56320 + {3'b0, a[10:0], 3'b0};
    else                   y = 17'd65536;
    return x[15] ? 17'(17'd65536 - y) : y;
  endfunction

  function automatic logic [31:0] fx_exp(input logic signed [15:0] x);
    logic signed [33:0] p;
    logic signed [25:0] t;
    logic signed [9:0]  n;
    logic [16:0]        m;
    logic [32:0]        v;
    logic [9:0]         nn;
    p  = $signed({{18{x[15]}}, x}) * 34'sd94548;
    t  = 26'(p >>> 8);
    n  = t[25:16];
    m  = {1'b1, t[15:0]};
    nn = 10'(-n);
    v  = 33'({16'b0, m} << n[3:0]);
    if (n >= 10'sd16) return 32'hFFFF_FFFF;
    if (n >= 10'sd0) return v[32] ? 32'hFFFF_FFFF : v[31:0];
    if (nn >= 10'd18) return 32'd0;
    return {15'b0, m >> nn[4:0]};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) return 24'sh7FFFFF;
    if (v < -50'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ycbd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ycbd_pkg for widths and the status struct.
`default_nettype none
module ycbd_div import ycbd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DivW-1:0]   dividend_i,
  input  wire logic [DsrW-1:0]   divisor_i,
  output div_stat_t              stat_o,
  output logic      [DivW-1:0]   quot_o
);
  logic [DivW-1:0] quot_q, quot_d;
  logic [DsrW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DsrW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DivW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 6'(DivW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = DsrW'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DsrW-1:0];
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
endmodule
`default_nettype wire

// ===== rtl/core/yolo_cell_box_decode.sv =====
// YOLO cell box decode: channels in over a stream, at most one detection out.
// Usage:
//   s_axis: one logit request per channel in order x, y, w, h, objectness,
//     then class scores; tlast marks the final class channel. Cell, grid,
//     anchor and net size fields are used from the tlast request only.
//   cfg: index 0 writes num_classes, index 1 the Q1.16 threshold; write idle.
//   m_axis: one detection (or layout error flagged in tuser) per tlast
//     request that qualifies; nothing when the score is below threshold.
// Sequencing:
//   Non-last channels take one cycle each. A tlast request goes to a check
//   state; a box below threshold is then done. A detection runs four
//   divisions on the shared 48-bit restoring divider, each a load, 48 bits
//   and a store, then a corner step and a size step before m_axis_tvalid.
//   A layout error goes from the check state straight to the output state.
//   s_axis_tready is low from tlast until the result is taken or dropped.
// Reset: registers return to num_classes 20 and threshold 16384, the
//   channel accumulators clear. A stalled receiver holds the detection in
//   the output register; accumulators clear when it is taken.
`default_nettype none
module yolo_cell_box_decode import ycbd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // logit[15:0] cell_col[23:16] cell_row[31:24] grid_width[40:32]
  // grid_height[49:41] anchor_width[65:50] anchor_height[81:66]
  // net_width[94:82] net_height[107:95], zero pad to 112
  input  wire logic [111:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // x_min[23:0] y_min[47:24] x_max[71:48] y_max[95:72] box_width[119:96]
  // box_height[143:120] class_id[150:144] score[167:151]
  output logic [167:0]      m_axis_tdata,
  // layout_error[0]
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [16:0]  cfg_data_i
);
  state_e state_q, state_d;

  logic [7:0]  nc_q;
  logic [16:0] thr_q;
  logic [7:0]  cnt_q, pos_q;
  logic [16:0] sig_x_q, sig_y_q, obj_q;
  logic [31:0] exp_w_q, exp_h_q;
  logic signed [15:0] best_q;
  logic [6:0]  best_cls_q;

  logic [7:0]  col_q, row_q;
  logic [8:0]  gw_q, gh_q;
  logic [15:0] aw_q, ah_q;
  logic [12:0] nw_q, nh_q;
  logic [1:0]  idx_q;
  logic [24:0] cx_q, cy_q;
  logic [42:0] hw_q, hh_q;

  logic signed [23:0] x0_q, y0_q, x1_q, y1_q, bw_q, bh_q;
  logic [6:0]  cls_out_q;
  logic [16:0] score_q;
  logic        err_q;

  logic signed [15:0] logit;
  logic        accept, clear, div_start, ok, below;
  logic [16:0] cls_sig, score;
  logic [33:0] sprod;
  logic [8:0]  gsel;
  logic [12:0] nsel;
  logic [47:0] dividend, mprod;
  logic [17:0] divisor;
  logic [47:0] quot;
  div_stat_t   dstat;

  assign logit       = $signed(s_axis_tdata[15:0]);
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // box check from the held accumulators
  assign ok = (pos_q != 8'd255) && (nc_q <= 8'(MaxClasses))
           && ({1'b0, pos_q} == 9'd4 + {1'b0, nc_q});
  assign cls_sig = (pos_q >= 8'd5) ? fx_sigmoid(best_q) : 17'd0;
  assign sprod   = obj_q * cls_sig;
  assign score   = sprod[32:16];
  assign below   = score < thr_q;

  // shared divider operands: centers first, then half sizes
  always_comb begin
    gsel  = idx_q[0] ? gh_q : gw_q;
    nsel  = idx_q[0] ? nh_q : nw_q;
    if (gsel == 9'd0) gsel = 9'd1;
    else if (gsel > 9'(MaxGrid)) gsel = 9'(MaxGrid);
    if (nsel == 13'd0) nsel = 13'd1;
    mprod = (idx_q[0] ? exp_h_q : exp_w_q) * (idx_q[0] ? ah_q : aw_q);
    if (idx_q[1]) begin
      dividend = mprod;
      divisor  = {nsel, 5'b0};
    end else begin
      dividend = 48'({idx_q[0] ? row_q : col_q, 16'b0})
               + 48'(idx_q[0] ? sig_y_q : sig_x_q);
      divisor  = {9'b0, gsel};
    end
  end

  ycbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .stat_o     (dstat),
    .quot_o     (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && s_axis_tlast) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!ok) state_d = ST_OUT;
        else if (below) state_d = ST_IDLE;
        else state_d = ST_LOAD;
      end
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (dstat.done) state_d = (idx_q == 2'd3) ? ST_FIN : ST_LOAD;
      ST_FIN:   state_d = ST_SIZE;
      ST_SIZE:  state_d = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    div_start     = (state_q == ST_LOAD);
    clear = ((state_q == ST_CHECK) && ok && below)
         || ((state_q == ST_OUT) && m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      nc_q       <= 8'd20;
      thr_q      <= 17'd16384;
      cnt_q      <= '0;
      sig_x_q    <= '0;
      sig_y_q    <= '0;
      obj_q      <= '0;
      exp_w_q    <= '0;
      exp_h_q    <= '0;
      best_q     <= '0;
      best_cls_q <= '0;
      idx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == RegNumClasses) nc_q <= cfg_data_i[7:0];
        else if (cfg_index_i == RegThreshold) thr_q <= cfg_data_i;
      end
      if (accept) begin
        unique case (cnt_q)
          8'd0: sig_x_q <= fx_sigmoid(logit);
          8'd1: sig_y_q <= fx_sigmoid(logit);
          8'd2: exp_w_q <= fx_exp(logit);
          8'd3: exp_h_q <= fx_exp(logit);
          8'd4: obj_q   <= fx_sigmoid(logit);
          8'd5: begin
            best_q     <= logit;
            best_cls_q <= '0;
          end
          default: begin
            // later class channels beyond the class limit drop out
            if (cnt_q < 8'(MaxClasses + 5) && logit > best_q) begin
              best_q     <= logit;
              best_cls_q <= 7'(cnt_q - 8'd5);
            end
          end
        endcase
        if (cnt_q != 8'd255) cnt_q <= cnt_q + 8'd1;
      end
      if (state_q == ST_CHECK) idx_q <= '0;
      if (state_q == ST_DIV && dstat.done) idx_q <= idx_q + 2'd1;
      if (clear) begin
        cnt_q      <= '0;
        sig_x_q    <= '0;
        sig_y_q    <= '0;
        obj_q      <= '0;
        exp_w_q    <= '0;
        exp_h_q    <= '0;
        best_q     <= '0;
        best_cls_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= cnt_q;
      col_q <= s_axis_tdata[23:16];
      row_q <= s_axis_tdata[31:24];
      gw_q  <= s_axis_tdata[40:32];
      gh_q  <= s_axis_tdata[49:41];
      aw_q  <= s_axis_tdata[65:50];
      ah_q  <= s_axis_tdata[81:66];
      nw_q  <= s_axis_tdata[94:82];
      nh_q  <= s_axis_tdata[107:95];
    end
    if (state_q == ST_DIV && dstat.done) begin
      unique case (idx_q)
        2'd0: cx_q <= quot[24:0];
        2'd1: cy_q <= quot[24:0];
        2'd2: hw_q <= quot[42:0];
        2'd3: hh_q <= quot[42:0];
        default: ;
      endcase
    end
    if (state_q == ST_CHECK) begin
      err_q     <= !ok;
      cls_out_q <= ok ? best_cls_q : '0;
      score_q   <= ok ? score : '0;
      x0_q <= '0; y0_q <= '0; x1_q <= '0; y1_q <= '0; bw_q <= '0; bh_q <= '0;
    end
    if (state_q == ST_FIN) begin
      x0_q <= sat24($signed({25'b0, cx_q}) - $signed({7'b0, hw_q}));
      x1_q <= sat24($signed({25'b0, cx_q}) + $signed({7'b0, hw_q}));
      y0_q <= sat24($signed({25'b0, cy_q}) - $signed({7'b0, hh_q}));
      y1_q <= sat24($signed({25'b0, cy_q}) + $signed({7'b0, hh_q}));
    end
    if (state_q == ST_SIZE) begin
      bw_q <= sat24(50'(x1_q) - 50'(x0_q) + 50'sd65536);
      bh_q <= sat24(50'(y1_q) - 50'(y0_q) + 50'sd65536);
    end
  end

  assign m_axis_tdata = {score_q, cls_out_q, bh_q, bw_q, y1_q, x1_q, y0_q, x0_q};
  assign m_axis_tuser = err_q;

  `include "yolo_cell_box_decode_assert.svh"

  `YCBD_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "input open while result held")
  `YCBD_ASSERT(a_err_zero, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == '0), "error with data")
  `YCBD_ASSERT(a_div_seq, !dstat.busy || (state_q == ST_DIV), "divider busy outside divide")
  `YCBD_ASSERT_NEXT(a_load, state_q == ST_LOAD, dstat.busy, "divider did not start")
endmodule
`default_nettype wire
